[rtl/msfe_pkg.sv]
// Package for the Manchester sensor frame encoder.
// Holds the frame layout constants, the byte index type and the chip coder.
// Used by every module of the block; depends on nothing.
package msfe_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  typedef logic [IdxW-1:0] byte_idx_t;

  localparam byte_idx_t IdxPre0  = byte_idx_t'(0);
  localparam byte_idx_t IdxPre1  = byte_idx_t'(1);
  localparam byte_idx_t IdxStart = byte_idx_t'(2);
  localparam byte_idx_t IdxSeq   = byte_idx_t'(3);
  localparam byte_idx_t IdxType  = byte_idx_t'(4);
  localparam byte_idx_t IdxTempH = byte_idx_t'(5);
  localparam byte_idx_t IdxTempL = byte_idx_t'(6);
  localparam byte_idx_t IdxHumH  = byte_idx_t'(7);
  localparam byte_idx_t IdxHumL  = byte_idx_t'(8);
  localparam byte_idx_t IdxCheck = byte_idx_t'(FrameLen - 1);

  localparam logic [7:0] Preamble0 = 8'hAA;
  localparam logic [7:0] Preamble1 = 8'hAB;
  localparam logic [7:0] StartByte = 8'hAC;
  localparam logic [7:0] TypeByte  = 8'h01;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } byte_word_t;

  // A one bit becomes chips 0 then 1, a zero bit chips 1 then 0, MSB first.
  function automatic logic [15:0] manchester_of(input logic [7:0] b);
    logic [15:0] chips;
    chips = '0;
    for (int k = 0; k < 8; k++) begin
      chips[2*k+1] = ~b[k];
      chips[2*k]   = b[k];
    end
    return chips;
  endfunction

endpackage

[rtl/manchester_sensor_frame_encoder.sv]
// Top level of the Manchester sensor frame encoder.
// Holds the address register and sequence number; instantiates
// msfe_frame_reg and msfe_out_reg. Depends on msfe_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   input   | in_valid, in_ready  | temperature, humidity, new_reading
//   output  | out_valid, out_ready| frame_byte, manchester_chips, last_byte
//   config  | cfg_wr_en           | cfg_wr_data (node address)
//
// Each reading gives ten words, one per cycle while the output does not stall;
// the byte counter of the frame register sets the count of words.
// The next reading is taken in the cycle in which its predecessor's checksum
// word moves into the result register, so frames follow without a gap.
// Reset clears the sequence number, the address and all valid state.
// A stall on the output holds the result register and the byte counter.
module manchester_sensor_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] temperature,
  input  logic [15:0] humidity,
  input  logic        new_reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic [15:0] manchester_chips,
  output logic        last_byte,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  logic [3:0]           node_address;
  logic [3:0]           sequence_number;
  logic [3:0]           sequence_number_next;
  logic                 load;
  logic                 busy;
  logic                 take_last;
  logic                 word_ready;
  msfe_pkg::byte_word_t word;

  assign in_ready = !busy || take_last;
  assign load     = in_valid && in_ready;
  assign sequence_number_next = new_reading ? sequence_number + 4'd1 : sequence_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_wr_en) begin
      node_address <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= '0;
    end else if (load) begin
      sequence_number <= sequence_number_next;
    end
  end

  msfe_frame_reg u_frame (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .temperature (temperature),
    .humidity    (humidity),
    .seq_num     (sequence_number_next),
    .addr        (node_address),
    .busy        (busy),
    .take_last   (take_last),
    .word        (word),
    .word_ready  (word_ready)
  );

  msfe_out_reg u_out (
    .clk              (clk),
    .rst              (rst),
    .word_valid       (busy),
    .word_ready       (word_ready),
    .word             (word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_byte       (frame_byte),
    .manchester_chips (manchester_chips),
    .last_byte        (last_byte)
  );

endmodule

[rtl/msfe_frame_reg.sv]
// Frame holding register of the Manchester sensor frame encoder.
// Captures one reading with its header fields and checksum, then offers
// the ten frame bytes in order. Depends on msfe_pkg.
module msfe_frame_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [15:0]         temperature,
  input  logic [15:0]         humidity,
  input  logic [3:0]          seq_num,
  input  logic [3:0]          addr,
  output logic                busy,
  output logic                take_last,
  output msfe_pkg::byte_word_t word,
  input  logic                word_ready
);

  logic [15:0]         temp_q;
  logic [15:0]         hum_q;
  logic [7:0]          seq_addr;
  logic [7:0]          check;
  msfe_pkg::byte_idx_t idx;
  logic [7:0]          seq_addr_next;
  logic [7:0]          check_next;
  logic [7:0]          byte_sel;
  logic                take;

  assign seq_addr_next = {seq_num, addr};
  assign check_next = msfe_pkg::StartByte ^ seq_addr_next ^ msfe_pkg::TypeByte
                      ^ temperature[15:8] ^ temperature[7:0]
                      ^ humidity[15:8] ^ humidity[7:0];

  assign take      = busy && word_ready;
  assign take_last = take && (idx == msfe_pkg::IdxCheck);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= msfe_pkg::IdxPre0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= msfe_pkg::IdxPre0;
    end else if (take) begin
      if (idx == msfe_pkg::IdxCheck) begin
        busy <= 1'b0;
        idx  <= msfe_pkg::IdxPre0;
      end else begin
        idx <= idx + msfe_pkg::byte_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      temp_q   <= temperature;
      hum_q    <= humidity;
      seq_addr <= seq_addr_next;
      check    <= check_next;
    end
  end

  always_comb begin
    case (idx)
      msfe_pkg::IdxPre0:  byte_sel = msfe_pkg::Preamble0;
      msfe_pkg::IdxPre1:  byte_sel = msfe_pkg::Preamble1;
      msfe_pkg::IdxStart: byte_sel = msfe_pkg::StartByte;
      msfe_pkg::IdxSeq:   byte_sel = seq_addr;
      msfe_pkg::IdxType:  byte_sel = msfe_pkg::TypeByte;
      msfe_pkg::IdxTempH: byte_sel = temp_q[15:8];
      msfe_pkg::IdxTempL: byte_sel = temp_q[7:0];
      msfe_pkg::IdxHumH:  byte_sel = hum_q[15:8];
      msfe_pkg::IdxHumL:  byte_sel = hum_q[7:0];
      msfe_pkg::IdxCheck: byte_sel = check;
      default:            byte_sel = check;
    endcase
  end

  assign word.frame_byte = byte_sel;
  assign word.last_byte  = (idx == msfe_pkg::IdxCheck);

endmodule

[rtl/msfe_out_reg.sv]
// Result register of the Manchester sensor frame encoder.
// Registers one frame byte with its Manchester chips and last flag.
// Depends on msfe_pkg.
module msfe_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 word_valid,
  output logic                 word_ready,
  input  msfe_pkg::byte_word_t word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           frame_byte,
  output logic [15:0]          manchester_chips,
  output logic                 last_byte
);

  assign word_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_ready) begin
      out_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      frame_byte       <= word.frame_byte;
      manchester_chips <= msfe_pkg::manchester_of(word.frame_byte);
      last_byte        <= word.last_byte;
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for manchester_sensor_frame_encoder.
// Drives sensor readings under random bursts and output stalls, predicts every frame word
// and compares it field by field. Depends on msfe_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned PrintLimit    = 30;

  typedef struct packed {
    logic [15:0] temp;
    logic [15:0] hum;
    logic        fresh;
  } reading_t;

  typedef struct packed {
    logic [7:0]  fbyte;
    logic [15:0] chips;
    logic        last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] temperature = '0;
  logic [15:0] humidity = '0;
  logic        new_reading = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic [15:0] manchester_chips;
  logic        last_byte;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        hold_off = 1'b0;

  reading_t    readings_q[$];
  frame_word_t frame_words_q[$];

  logic [3:0]  seq_copy = '0;
  logic [3:0]  addr_copy = '0;
  int unsigned readings_taken = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned addr_writes = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  manchester_sensor_frame_encoder dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .temperature      (temperature),
    .humidity         (humidity),
    .new_reading      (new_reading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_byte       (frame_byte),
    .manchester_chips (manchester_chips),
    .last_byte        (last_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] chips_of(input logic [7:0] b);
    logic [15:0] c;
    c = '0;
    for (int i = 7; i >= 0; i--) c = {c[13:0], (b[i] ? 2'b01 : 2'b10)};
    return c;
  endfunction

  task automatic build_frame(input logic [15:0] temp, input logic [15:0] hum,
                             input logic fresh);
    logic [7:0]  fb [msfe_pkg::FrameLen];
    logic [7:0]  sum;
    frame_word_t w;
    if (fresh) seq_copy = seq_copy + 4'd1;
    fb[msfe_pkg::IdxPre0]  = msfe_pkg::Preamble0;
    fb[msfe_pkg::IdxPre1]  = msfe_pkg::Preamble1;
    fb[msfe_pkg::IdxStart] = msfe_pkg::StartByte;
    fb[msfe_pkg::IdxSeq]   = {seq_copy, addr_copy};
    fb[msfe_pkg::IdxType]  = msfe_pkg::TypeByte;
    fb[msfe_pkg::IdxTempH] = temp[15:8];
    fb[msfe_pkg::IdxTempL] = temp[7:0];
    fb[msfe_pkg::IdxHumH]  = hum[15:8];
    fb[msfe_pkg::IdxHumL]  = hum[7:0];
    sum = 8'h00;
    for (int i = msfe_pkg::IdxStart; i < msfe_pkg::IdxCheck; i++) sum = sum ^ fb[i];
    fb[msfe_pkg::IdxCheck] = sum;
    for (int i = 0; i < msfe_pkg::FrameLen; i++) begin
      w.fbyte = fb[i];
      w.chips = chips_of(fb[i]);
      w.last  = (i == msfe_pkg::IdxCheck);
      frame_words_q.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < PrintLimit)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_reading(input logic [15:0] temp, input logic [15:0] hum,
                               input logic fresh);
    reading_t r;
    r.temp  = temp;
    r.hum   = hum;
    r.fresh = fresh;
    readings_q.push_back(r);
  endtask

  function automatic logic [15:0] random_field();
    logic [15:0] v;
    case ($urandom_range(0, 11))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'hFFFF;
      3:       v = 16'h0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (readings_q.size() != 0 || in_valid || frame_words_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_address(input logic [3:0] a);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    addr_copy = a;
    addr_writes++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : sender
    reading_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        build_frame(temperature, humidity, new_reading);
        readings_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || readings_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt = readings_q.pop_front();
          temperature <= nxt.temp;
          humidity    <= nxt.hum;
          new_reading <= nxt.fresh;
          in_valid    <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    logic [7:0]  stall_pat;
    int unsigned pat_age;
    if (rst) begin
      out_ready <= 1'b0;
      stall_pat = 8'hFF;
      pat_age = 0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       stall_pat = 8'hFF;
          default: stall_pat = 8'($urandom) | 8'h01;
        endcase
      end
      pat_age--;
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      out_ready <= stall_pat[0] && !hold_off;
    end
  end

  always @(posedge clk) begin : word_checker
    frame_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (frame_words_q.size() == 0) begin
        report_mismatch("unexpected word", {8'h00, frame_byte}, 16'h0000);
      end else begin
        want = frame_words_q.pop_front();
        if (frame_byte !== want.fbyte)
          report_mismatch("frame_byte", {8'h00, frame_byte}, {8'h00, want.fbyte});
        if (manchester_chips !== want.chips)
          report_mismatch("manchester_chips", manchester_chips, want.chips);
        if (last_byte !== want.last)
          report_mismatch("last_byte", {15'h0, last_byte}, {15'h0, want.last});
      end
    end
  end

  initial begin : long_hold_off
    wait (readings_taken >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    logic [3:0] addr_plan [6];
    addr_plan = '{4'hF, 4'h0, 4'h9, 4'h6, 4'hF, 4'h0};
    addr_plan[5] = 4'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // A retransmission before any new reading keeps sequence number zero.
    queue_reading(16'h0000, 16'h0000, 1'b0);
    queue_reading(16'h8000, 16'hFFFF, 1'b1);
    queue_reading(16'h7FFF, 16'h0000, 1'b1);
    queue_reading(16'hFFFF, 16'hFFFF, 1'b0);
    queue_reading(16'h5555, 16'hAAAA, 1'b1);
    queue_reading(16'hAAAA, 16'h5555, 1'b0);
    queue_reading(16'h00FF, 16'hFF00, 1'b1);
    queue_reading(16'hFF00, 16'h00FF, 1'b1);
    // Sixteen new readings in a row carry the sequence number through its wrap.
    for (int i = 0; i < 16; i++) queue_reading(random_field(), random_field(), 1'b1);
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_address(addr_plan[p]);
      for (int i = 0; i < 44; i++)
        queue_reading(random_field(), random_field(), ($urandom_range(0, 3) != 0));
    end
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Encoded %0d readings under %0d address writes; %0d frame words compared.",
             readings_taken, addr_writes, words_checked);
    $display("Output was held off for %0d cycles while readings kept arriving.",
             HoldOffCycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Run did not finish in time.");
    $display("TEST FAILED");
    $finish;
  end

endmodule
